// ----- sv/sdtq_pkg.sv -----
// Shared constants, types and codes for the sorted deadline timer queue.
package sdtq_pkg;

  localparam int DEPTH        = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int DL_W         = 64;
  localparam int DELAY_W      = 16;
  localparam int TASK_W       = 8;
  localparam int FREQ_W       = 32;
  localparam int PROD_W       = DELAY_W + FREQ_W;
  localparam int NPOP_W       = $clog2(MAX_RESULTS + 1);
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 80;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(19200000);
  localparam logic [DL_W-1:0]   ALL_ONES   = '1;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_IRQ = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [DL_W-1:0]   deadline;
    logic [TASK_W-1:0] task_id;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DL_W-1:0]   deadline;
    logic [TASK_W-1:0] task_id;
  } chain_ctrl_t;

  typedef struct packed {
    entry_t head;
    logic   full;
  } chain_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_INS,
    S_POP,
    S_EMIT
  } state_t;

endpackage

// ----- sv/sorted_deadline_timer_queue.sv -----
// Sorted deadline timer queue: command sequencer, deadline arithmetic and output register.
// An add steps through multiply, add, chain insert and emit after acceptance.
// An interrupt gives at least one result, each from a chain shift and then its emit.
// The next item is accepted the cycle after the final result of the previous one is
// registered; a stalled output register holds the sequencer in its emit step.
// Reset (rst_n low, synchronous) empties the chain and sets counter_frequency to 19200000.
module sorted_deadline_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,   // counter_frequency
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // now[63:0], delay_seconds[79:64], task_id[87:80]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // fired_task[7:0], compare_value[71:8],
                                  // queue_empty[72], dropped[73], zero pad
  output logic        out_tuser,  // fired
  output logic        out_tlast   // last
);
  import sdtq_pkg::*;

  state_t state_r, state_nxt;

  logic [FREQ_W-1:0]  freq_r;
  logic               cmd_r;
  logic [DL_W-1:0]    now_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TASK_W-1:0]  task_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DL_W-1:0]    dl_r;
  logic               fired_r;
  logic [TASK_W-1:0]  ftask_r;
  logic               drop_r;
  logic [NPOP_W-1:0]  npop_r;

  logic               out_valid_r;
  logic [TASK_W-1:0]  o_task_r;
  logic [DL_W-1:0]    o_cmp_r;
  logic               o_empty_r;
  logic               o_drop_r;
  logic               o_fired_r;
  logic               o_last_r;

  chain_ctrl_t ctrl;
  chain_stat_t stat;

  logic in_acc;
  logic slot_free;
  logic emit;
  logic more;

  sdtq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Another pop follows only after a real pop, while the new head has expired
  // and the per-interrupt budget is not used up.
  assign more = fired_r && stat.head.valid && (stat.head.deadline <= now_r)
                && (npop_r < NPOP_W'(MAX_RESULTS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == CMD_ADD) ? S_MUL : S_POP;
        end
      end
      S_MUL:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_INS;
      S_INS:  state_nxt = S_EMIT;
      S_POP:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = more ? S_POP : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    emit          = 1'b0;
    ctrl.op       = OP_HOLD;
    ctrl.deadline = dl_r;
    ctrl.task_id  = task_r;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_INS: begin
        if (!stat.full) begin
          ctrl.op = OP_INSERT;
        end
      end
      S_POP: begin
        if (stat.head.valid) begin
          ctrl.op = OP_POP;
        end
      end
      S_EMIT: emit = slot_free;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      freq_r      <= FREQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        freq_r <= cfg_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser;
      now_r   <= in_tdata[63:0];
      delay_r <= in_tdata[79:64];
      task_r  <= in_tdata[87:80];
      npop_r  <= '0;
      fired_r <= 1'b0;
      ftask_r <= '0;
      drop_r  <= 1'b0;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(delay_r) * PROD_W'(freq_r);
    end
    if (state_r == S_ADD) begin
      dl_r <= now_r + DL_W'(prod_r);
    end
    if (state_r == S_INS) begin
      drop_r <= stat.full;
    end
    if (state_r == S_POP) begin
      if (stat.head.valid) begin
        fired_r <= 1'b1;
        ftask_r <= stat.head.task_id;
        npop_r  <= npop_r + NPOP_W'(1);
      end else begin
        fired_r <= 1'b0;
        ftask_r <= '0;
      end
    end
    if (emit) begin
      o_task_r  <= ftask_r;
      o_cmp_r   <= stat.head.valid ? stat.head.deadline : ALL_ONES;
      o_empty_r <= !stat.head.valid;
      o_drop_r  <= (cmd_r == CMD_ADD) ? drop_r : 1'b0;
      o_fired_r <= fired_r;
      o_last_r  <= !more;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, o_drop_r, o_empty_r, o_cmp_r, o_task_r};
  assign out_tuser  = o_fired_r;
  assign out_tlast  = o_last_r;

endmodule

// ----- sv/sdtq_cell.sv -----
// One slot of the sorted timer chain: holds an entry and shifts with its neighbors.
module sdtq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdtq_pkg::chain_ctrl_t ctrl,
  input  sdtq_pkg::entry_t     left_ent,
  input  logic                 left_ge,
  input  sdtq_pkg::entry_t     right_ent,
  output sdtq_pkg::entry_t     ent,
  output logic                 ge
);
  import sdtq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An empty slot counts as an infinite deadline, so the slots that move
  // on an insert always form a tail of the chain.
  always_comb begin
    ge      = !ent_r.valid || (ent_r.deadline >= ctrl.deadline);
    ent_nxt = ent_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (ge) begin
          if (left_ge) begin
            ent_nxt = left_ent;
          end else begin
            ent_nxt.valid    = 1'b1;
            ent_nxt.deadline = ctrl.deadline;
            ent_nxt.task_id  = ctrl.task_id;
          end
        end
      end
      OP_POP:  ent_nxt = right_ent;
      default: ent_nxt = ent_r;
    endcase
  end

  // Only the valid bit is reset; the payload is ignored while it is clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.deadline <= ent_nxt.deadline;
    ent_r.task_id  <= ent_nxt.task_id;
  end

  assign ent = ent_r;

endmodule

// ----- sv/sdtq_chain.sv -----
// Row of timer cells kept sorted by deadline, head at cell zero.
module sdtq_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdtq_pkg::chain_ctrl_t ctrl,
  output sdtq_pkg::chain_stat_t stat
);
  import sdtq_pkg::*;

  entry_t ents [DEPTH];
  logic   ges  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_w;
    logic   left_ge_w;
    entry_t right_w;

    if (i == 0) begin : g_first
      assign left_w    = '0;
      assign left_ge_w = 1'b0;
    end else begin : g_mid
      assign left_w    = ents[i-1];
      assign left_ge_w = ges[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = ents[i+1];
    end

    sdtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_ent  (left_w),
      .left_ge   (left_ge_w),
      .right_ent (right_w),
      .ent       (ents[i]),
      .ge        (ges[i])
    );
  end

  assign stat.head = ents[0];
  assign stat.full = ents[DEPTH-1].valid;

endmodule
